// ----- rtl/i2cmra_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cmra_pkg
// Types and constants shared by the bit-level I2C register access master.
// ----------------------------------------------------------------------------
package i2cmra_pkg;

  // item kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  // transaction status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CHIP_NAK = 2'd1;
  localparam logic [1:0] ST_REG_NAK  = 2'd2;

  localparam int MAX_ADDR_BYTES = 4;
  localparam int READ_LIMIT     = 16;

  typedef struct packed {
    logic [1:0]  kind;
    logic        sda_in;
    logic        is_read;
    logic [6:0]  chip_addr;
    logic [31:0] reg_addr;
    logic [2:0]  addr_len;
    logic [7:0]  data_byte;
    logic [4:0]  byte_count;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_data;
    logic       done_res;
    logic [1:0] status;
    logic [4:0] data_nacks;
  } result_t;

endpackage

// ----- rtl/i2cmra_seq.sv -----
// ----------------------------------------------------------------------------
// i2cmra_seq
// Quarter-bit I2C sequencer: transaction state, write byte buffer and the
// next-state / line-level logic for one item.
// ----------------------------------------------------------------------------
module i2cmra_seq #(
  parameter int BUFFER_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  i2cmra_pkg::item_t   item,
  output i2cmra_pkg::result_t result
);
  import i2cmra_pkg::*;

  localparam int IDX_W  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);

  typedef enum logic [3:0] {
    PH_IDLE, PH_START, PH_CHIPW, PH_REGADDR, PH_RSTART,
    PH_CHIPR, PH_WDATA, PH_RDATA, PH_STOP
  } phase_t;

  phase_t            phase, phase_next;
  logic [1:0]        quarter, quarter_next;
  logic [3:0]        bit_idx, bit_idx_next;
  logic [7:0]        shift_byte, shift_byte_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [FILL_W-1:0] rd_ptr, rd_ptr_next;
  logic [4:0]        bytes_left, bytes_left_next;
  logic [2:0]        addr_left, addr_left_next;
  logic [31:0]       req_addr, req_addr_next;
  logic [6:0]        req_chip, req_chip_next;
  logic              req_read, req_read_next;
  logic [4:0]        nack_cnt, nack_cnt_next;
  logic              line_scl, line_scl_next;
  logic              line_sda, line_sda_next;
  logic [1:0]        status, status_next;

  logic [7:0] mem [BUFFER_DEPTH];
  logic [7:0] buf_q;
  logic       wr_en;

  logic       rd_valid;
  logic [7:0] rd_byte;
  logic       done;

  logic       byte_ph;
  logic       lvl;
  logic       go_reg, go_addr_done, go_wdata, go_read;
  logic [1:0] sel;
  logic [2:0] alen;

  always_comb begin
    phase_next      = phase;
    quarter_next    = quarter;
    bit_idx_next    = bit_idx;
    shift_byte_next = shift_byte;
    fill_next       = fill;
    rd_ptr_next     = rd_ptr;
    bytes_left_next = bytes_left;
    addr_left_next  = addr_left;
    req_addr_next   = req_addr;
    req_chip_next   = req_chip;
    req_read_next   = req_read;
    nack_cnt_next   = nack_cnt;
    line_scl_next   = line_scl;
    line_sda_next   = line_sda;
    status_next     = status;
    wr_en           = 1'b0;
    rd_valid        = 1'b0;
    rd_byte         = 8'd0;
    done            = 1'b0;
    go_reg          = 1'b0;
    go_addr_done    = 1'b0;
    go_wdata        = 1'b0;
    go_read         = 1'b0;
    sel             = 2'd0;
    alen            = 3'd0;
    byte_ph = (phase != PH_START) && (phase != PH_RSTART) && (phase != PH_STOP);

    if (phase == PH_START || phase == PH_RSTART) begin
      lvl = 1'b1;
    end else if (phase == PH_STOP) begin
      lvl = 1'b0;
    end else if (bit_idx >= 4'd8) begin
      lvl = (phase == PH_RDATA) ? (bytes_left <= 5'd1) : 1'b1;
    end else begin
      lvl = (phase == PH_RDATA) ? 1'b1 : shift_byte[7];
    end

    if (step) begin
      case (item.kind)
        KIND_TICK: begin
          if (phase != PH_IDLE) begin
            line_scl_next = quarter[1];
            if (quarter == 2'd0) begin
              line_sda_next = line_sda;
            end else if (quarter == 2'd3 && (phase == PH_START || phase == PH_RSTART)) begin
              line_sda_next = 1'b0;
            end else if (quarter == 2'd3 && phase == PH_STOP) begin
              line_sda_next = 1'b1;
            end else begin
              line_sda_next = lvl;
            end
            quarter_next = quarter + 2'd1;

            if (quarter == 2'd3) begin
              if (byte_ph && bit_idx < 4'd8) begin
                shift_byte_next = {shift_byte[6:0],
                                   (phase == PH_RDATA) ? item.sda_in : 1'b0};
                if (phase == PH_RDATA && bit_idx == 4'd7) begin
                  rd_valid = 1'b1;
                  rd_byte  = shift_byte_next;
                end
                bit_idx_next = bit_idx + 4'd1;
              end else if (byte_ph) begin
                // acknowledge slot
                bit_idx_next = 4'd0;
                case (phase)
                  PH_CHIPW, PH_REGADDR: begin
                    if (item.sda_in) begin
                      status_next = (phase == PH_CHIPW) ? ST_CHIP_NAK : ST_REG_NAK;
                      phase_next  = PH_STOP;
                    end else if (addr_left != 3'd0) begin
                      go_reg = 1'b1;
                    end else begin
                      go_addr_done = 1'b1;
                    end
                  end
                  PH_WDATA: begin
                    if (item.sda_in && nack_cnt != 5'd31) begin
                      nack_cnt_next = nack_cnt + 5'd1;
                    end
                    if (bytes_left != 5'd0) begin
                      bytes_left_next = bytes_left - 5'd1;
                    end
                    go_wdata = 1'b1;
                  end
                  PH_CHIPR: begin
                    go_read = 1'b1;
                  end
                  default: begin
                    if (bytes_left != 5'd0) begin
                      bytes_left_next = bytes_left - 5'd1;
                    end
                    go_read = 1'b1;
                  end
                endcase
              end else if (phase == PH_START) begin
                phase_next      = (req_read && addr_left == 3'd0) ? PH_CHIPR : PH_CHIPW;
                shift_byte_next = {req_chip, req_read && addr_left == 3'd0};
                bit_idx_next    = 4'd0;
              end else if (phase == PH_RSTART) begin
                phase_next      = PH_CHIPR;
                shift_byte_next = {req_chip, 1'b1};
                bit_idx_next    = 4'd0;
              end else begin
                phase_next = PH_IDLE;
                fill_next  = '0;
                done       = 1'b1;
              end
            end
          end
        end
        KIND_LOAD: begin
          if (phase == PH_IDLE && fill < FILL_W'(BUFFER_DEPTH)) begin
            wr_en     = 1'b1;
            fill_next = fill + FILL_W'(1);
          end
        end
        KIND_START: begin
          if (phase == PH_IDLE) begin
            alen = (item.addr_len > 3'(MAX_ADDR_BYTES)) ? 3'(MAX_ADDR_BYTES) : item.addr_len;
            if (item.is_read) begin
              bytes_left_next = (item.byte_count > 5'(READ_LIMIT)) ?
                                5'(READ_LIMIT) : item.byte_count;
            end else begin
              bytes_left_next = (int'(item.byte_count) > BUFFER_DEPTH) ?
                                5'(BUFFER_DEPTH) : item.byte_count;
            end
            addr_left_next  = alen;
            req_addr_next   = item.reg_addr;
            req_chip_next   = item.chip_addr;
            req_read_next   = item.is_read;
            nack_cnt_next   = 5'd0;
            status_next     = ST_OK;
            quarter_next    = 2'd0;
            bit_idx_next    = 4'd0;
            shift_byte_next = 8'd0;
            rd_ptr_next     = '0;
            phase_next      = PH_START;
          end
        end
        default: ;
      endcase

      if (go_reg) begin
        addr_left_next  = addr_left - 3'd1;
        sel             = addr_left_next[1:0];
        shift_byte_next = 8'(req_addr >> {sel, 3'b000});
        phase_next      = PH_REGADDR;
      end
      if (go_addr_done) begin
        if (req_read) begin
          phase_next = PH_RSTART;
        end else begin
          go_wdata = 1'b1;
        end
      end
      if (go_wdata) begin
        if (bytes_left_next != 5'd0) begin
          phase_next      = PH_WDATA;
          // entries past the fill level send zero
          shift_byte_next = (rd_ptr < fill) ? buf_q : 8'd0;
          rd_ptr_next     = rd_ptr + FILL_W'(1);
        end else begin
          phase_next = PH_STOP;
        end
      end
      if (go_read) begin
        if (bytes_left_next != 5'd0) begin
          phase_next      = PH_RDATA;
          shift_byte_next = 8'd0;
        end else begin
          phase_next = PH_STOP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      quarter    <= 2'd0;
      bit_idx    <= 4'd0;
      shift_byte <= 8'd0;
      fill       <= '0;
      rd_ptr     <= '0;
      bytes_left <= 5'd0;
      addr_left  <= 3'd0;
      req_addr   <= 32'd0;
      req_chip   <= 7'd0;
      req_read   <= 1'b0;
      nack_cnt   <= 5'd0;
      line_scl   <= 1'b1;
      line_sda   <= 1'b1;
      status     <= ST_OK;
    end else begin
      phase      <= phase_next;
      quarter    <= quarter_next;
      bit_idx    <= bit_idx_next;
      shift_byte <= shift_byte_next;
      fill       <= fill_next;
      rd_ptr     <= rd_ptr_next;
      bytes_left <= bytes_left_next;
      addr_left  <= addr_left_next;
      req_addr   <= req_addr_next;
      req_chip   <= req_chip_next;
      req_read   <= req_read_next;
      nack_cnt   <= nack_cnt_next;
      line_scl   <= line_scl_next;
      line_sda   <= line_sda_next;
      status     <= status_next;
    end
  end

  // write buffer; read port prefetches the next byte to send
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill[IDX_W-1:0]] <= item.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    buf_q <= mem[rd_ptr_next[IDX_W-1:0]];
  end

  always_comb begin
    result.scl_level  = line_scl_next;
    result.sda_level  = line_sda_next;
    result.busy_res   = (phase_next != PH_IDLE);
    result.read_valid = rd_valid;
    result.read_data  = rd_byte;
    result.done_res   = done;
    result.status     = status_next;
    result.data_nacks = nack_cnt_next;
  end

`ifndef ASSERT_OFF
  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_idx <= 4'd8)
    else $error("bit index past acknowledge slot");

  a_idle_aligned: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (quarter == 2'd0 && bit_idx == 4'd0))
    else $error("idle with a partial bit slot");

  a_idle_lines: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (line_scl && line_sda))
    else $error("bus not released while idle");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(BUFFER_DEPTH))
    else $error("write buffer overfilled");

  a_done_alone: assert property (@(posedge clk) disable iff (rst)
    (step && done) |-> (!rd_valid && phase_next == PH_IDLE))
    else $error("stop completion mixed with read data");
`endif

endmodule

// ----- rtl/i2c_master_register_access.sv -----
// ----------------------------------------------------------------------------
// i2c_master_register_access
// Bit-level I2C master for register reads and writes, one quarter bit per tick.
// ----------------------------------------------------------------------------
// Usage:
//   item / item_valid / item_stall carry commands in: kind 2 opens a
//   transaction (chip, register address, direction, byte count), kind 1
//   loads a write byte while idle, kind 0 is one quarter-bit tick that
//   samples sda_in and advances the bus sequence.
//   result / result_valid / result_stall return one result per item: the
//   SCL and SDA levels to drive, busy, a received byte when read_valid is
//   set, done on the STOP tick, status and the data NACK count.
//   The result is registered behind the one-item input register and the
//   sequencer; one item is taken every cycle while result_stall is low. The
//   sequencer state register is the only loop.
//   Reset idles the bus with both lines high, clears the write buffer fill
//   and status; there is no clearing pass.
//   A stalled result holds in the output register; the one-item input
//   register still takes a transfer while empty, then raises item_stall.
// ----------------------------------------------------------------------------
module i2c_master_register_access #(
  parameter int BUFFER_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  i2cmra_pkg::item_t   item,
  output logic                result_valid,
  input  logic                result_stall,
  output i2cmra_pkg::result_t result
);
  import i2cmra_pkg::*;

  logic    hold_valid;
  item_t   hold_item;
  logic    step;
  result_t seq_result;

  assign step       = hold_valid && (!result_valid || !result_stall);
  assign item_stall = hold_valid && !step;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (!item_stall) begin
        hold_valid <= item_valid;
      end
      if (step) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      hold_item <= item;
    end
    if (step) begin
      result <= seq_result;
    end
  end

  i2cmra_seq #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_seq (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .item  (hold_item),
    .result(seq_result)
  );

endmodule
